>>> src/tga_pkg.sv
// Shared types and constants for the TGA stream decoder.
package tga_pkg;

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_HEAD   = 7'b0000010,
      PH_IDSKIP = 7'b0000100,
      PH_PKT    = 7'b0001000,
      PH_PIX    = 7'b0010000,
      PH_DONE   = 7'b0100000,
      PH_ERR    = 7'b1000000
   } tga_phase_type;

   typedef enum logic [2:0] {
      ST_SPAN      = 3'd0,
      ST_HEADER_OK = 3'd1,
      ST_BAD_TYPE  = 3'd2,
      ST_BAD_DEPTH = 3'd3,
      ST_TRUNCATED = 3'd4
   } tga_status_type;

   // header byte positions
   localparam logic [4:0] HDR_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_TYPE      = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_DESC      = 5'd17;

   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] TYPE_RLE = 8'd10;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   localparam logic [2:0] BPP_NONE = 3'd0;
   localparam logic [2:0] BPP_RGB  = 3'd3;
   localparam logic [2:0] BPP_RGBA = 3'd4;

   localparam int         PKT_RUN_BIT    = 7;
   localparam logic [6:0] PKT_COUNT_MASK = 7'h7f;

   // response queue entries; pointers wrap naturally, so keep a power of two
   localparam int         QUEUE_DEPTH    = 4;

   typedef struct packed {
      tga_status_type status;
      logic [7:0]     red;
      logic [7:0]     green;
      logic [7:0]     blue;
      logic [7:0]     alpha;
      logic [7:0]     repeat_res;
      logic           last_pixel;
      logic [15:0]    width;
      logic [15:0]    height;
      logic           has_alpha;
   } tga_result_type;

   // results of one request, packed from the front
   typedef struct packed {
      logic [1:0]     count;
      tga_result_type first;
      tga_result_type second;
   } tga_emit_type;

endpackage

>>> src/tga_dec_core.sv
// Header parser and pixel packet decoder: running state and per-request results.
module tga_dec_core
   import tga_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_fire,
   input  logic [7:0]   in_byte,
   input  logic         in_first,
   input  logic         in_last,
   output tga_emit_type emit_out
);

   tga_phase_type phase_ff, phase_in, phase_eff;
   logic [4:0]  header_index_ff, header_index_in, header_index_eff;
   logic [7:0]  id_skip_ff, id_skip_in, id_skip_eff;
   logic        run_coded_ff, run_coded_in, run_coded_eff;
   logic [2:0]  bpp_ff, bpp_in, bpp_eff;
   logic [15:0] width_ff, width_in, width_eff;
   logic [15:0] height_ff, height_in, height_eff;
   logic [31:0] pixels_ff, pixels_in, pixels_eff;
   logic [7:0]  packet_ff, packet_in, packet_eff;
   logic        is_run_ff, is_run_in, is_run_eff;
   logic [1:0]  cidx_ff, cidx_in, cidx_eff;
   logic [31:0] colour_ff, colour_in, colour_eff;

   logic [31:0] col_new;
   logic        pixel_done;
   logic        run_span;
   logic [7:0]  rep;
   logic [31:0] pixels_after;
   logic [7:0]  packet_after;
   logic        span_last;
   logic        pixels_zero;
   logic        have_main;
   logic        trunc;
   tga_result_type main_res;
   tga_result_type trunc_res;

   function automatic tga_result_type make_result(
      input tga_status_type st,
      input logic [31:0]    col,
      input logic [7:0]     rp,
      input logic           lst,
      input logic [15:0]    w,
      input logic [15:0]    h,
      input logic [2:0]     bpp
   );
      tga_result_type r;
      r.status     = st;
      r.red        = col[23:16];
      r.green      = col[15:8];
      r.blue       = col[7:0];
      r.alpha      = (bpp == BPP_RGBA) ? col[31:24] : 8'd0;
      r.repeat_res = rp;
      r.last_pixel = lst;
      r.width      = w;
      r.height     = h;
      r.has_alpha  = (bpp == BPP_RGBA);
      return r;
   endfunction

   // a first byte restarts from the reset state in header phase
   always_comb begin
      if (in_first) begin
         phase_eff        = PH_HEAD;
         header_index_eff = '0;
         id_skip_eff      = '0;
         run_coded_eff    = 1'b0;
         bpp_eff          = BPP_NONE;
         width_eff        = '0;
         height_eff       = '0;
         pixels_eff       = '0;
         packet_eff       = '0;
         is_run_eff       = 1'b0;
         cidx_eff         = '0;
         colour_eff       = '0;
      end else begin
         phase_eff        = phase_ff;
         header_index_eff = header_index_ff;
         id_skip_eff      = id_skip_ff;
         run_coded_eff    = run_coded_ff;
         bpp_eff          = bpp_ff;
         width_eff        = width_ff;
         height_eff       = height_ff;
         pixels_eff       = pixels_ff;
         packet_eff       = packet_ff;
         is_run_eff       = is_run_ff;
         cidx_eff         = cidx_ff;
         colour_eff       = colour_ff;
      end
   end

   // pixel datapath
   always_comb begin
      col_new    = colour_eff | ({24'd0, in_byte} << {cidx_eff, 3'b000});
      pixel_done = ({1'b0, cidx_eff} + 3'd1) >= bpp_eff;
      run_span   = run_coded_eff && is_run_eff;
      if (run_span) begin
         rep = ({24'd0, packet_eff} < pixels_eff) ? packet_eff : pixels_eff[7:0];
      end else begin
         rep = 8'd1;
      end
      pixels_after = pixels_eff - {24'd0, rep};
      span_last    = (pixels_after == 32'd0);
      if (run_span) begin
         packet_after = 8'd0;
      end else if (run_coded_eff && packet_eff != 8'd0) begin
         packet_after = packet_eff - 8'd1;
      end else begin
         packet_after = packet_eff;
      end
      pixels_zero = (pixels_eff == 32'd0);
   end

   always_comb begin
      phase_in        = phase_eff;
      header_index_in = header_index_eff;
      id_skip_in      = id_skip_eff;
      run_coded_in    = run_coded_eff;
      bpp_in          = bpp_eff;
      width_in        = width_eff;
      height_in       = height_eff;
      pixels_in       = pixels_eff;
      packet_in       = packet_eff;
      is_run_in       = is_run_eff;
      cidx_in         = cidx_eff;
      colour_in       = colour_eff;
      have_main       = 1'b0;
      main_res        = make_result(ST_SPAN, 32'd0, 8'd0, 1'b0,
                                    width_eff, height_eff, bpp_eff);

      unique case (phase_eff)
         PH_HEAD: begin
            unique case (header_index_eff)
               HDR_ID_LEN: id_skip_in = in_byte;
               HDR_TYPE: begin
                  if (in_byte == TYPE_RAW || in_byte == TYPE_RLE) begin
                     run_coded_in = (in_byte == TYPE_RLE);
                  end else begin
                     have_main       = 1'b1;
                     main_res.status = ST_BAD_TYPE;
                     phase_in        = PH_ERR;
                  end
               end
               HDR_WIDTH_LO:  width_in  = {width_eff[15:8], in_byte};
               HDR_WIDTH_HI:  width_in  = {in_byte, width_eff[7:0]};
               HDR_HEIGHT_LO: height_in = {height_eff[15:8], in_byte};
               HDR_HEIGHT_HI: height_in = {in_byte, height_eff[7:0]};
               HDR_DEPTH: begin
                  if (in_byte == DEPTH_24 || in_byte == DEPTH_32) begin
                     bpp_in = (in_byte == DEPTH_32) ? BPP_RGBA : BPP_RGB;
                  end else begin
                     have_main       = 1'b1;
                     main_res.status = ST_BAD_DEPTH;
                     phase_in        = PH_ERR;
                  end
               end
               HDR_DESC: begin
                  have_main       = 1'b1;
                  main_res.status = ST_HEADER_OK;
                  pixels_in       = {16'd0, width_eff} * {16'd0, height_eff};
                  if (id_skip_eff != 8'd0) begin
                     phase_in = PH_IDSKIP;
                  end else begin
                     if (width_eff == 16'd0 || height_eff == 16'd0) begin
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = run_coded_eff ? PH_PKT : PH_PIX;
                     end
                     cidx_in   = '0;
                     colour_in = '0;
                     packet_in = '0;
                     is_run_in = 1'b0;
                  end
               end
               default: ;
            endcase
            if (header_index_eff < HDR_DESC) begin
               header_index_in = header_index_eff + 5'd1;
            end
         end
         PH_IDSKIP: begin
            id_skip_in = id_skip_eff - 8'd1;
            if (id_skip_eff == 8'd1) begin
               if (pixels_zero) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = run_coded_eff ? PH_PKT : PH_PIX;
               end
               cidx_in   = '0;
               colour_in = '0;
               packet_in = '0;
               is_run_in = 1'b0;
            end
         end
         PH_PKT: begin
            is_run_in = in_byte[PKT_RUN_BIT];
            packet_in = {1'b0, in_byte[6:0] & PKT_COUNT_MASK} + 8'd1;
            cidx_in   = '0;
            colour_in = '0;
            phase_in  = PH_PIX;
         end
         PH_PIX: begin
            if (pixel_done) begin
               packet_in = packet_after;
               pixels_in = pixels_after;
               have_main = 1'b1;
               main_res  = make_result(ST_SPAN, col_new, rep, span_last,
                                       width_eff, height_eff, bpp_eff);
               cidx_in   = '0;
               colour_in = '0;
               if (span_last) begin
                  phase_in = PH_DONE;
               end else if (run_coded_eff && packet_after == 8'd0) begin
                  phase_in = PH_PKT;
               end
            end else begin
               colour_in = col_new;
               cidx_in   = cidx_eff + 2'd1;
            end
         end
         default: ;
      endcase

      trunc = 1'b0;
      if (in_last) begin
         trunc = (phase_in == PH_HEAD) || (phase_in == PH_IDSKIP) ||
                 (phase_in == PH_PKT) || (phase_in == PH_PIX);
         phase_in = PH_IDLE;
      end
   end

   always_comb begin
      trunc_res = make_result(ST_TRUNCATED, 32'd0, 8'd0, 1'b0,
                              width_in, height_in, bpp_in);
      emit_out.count  = {1'b0, have_main} + {1'b0, trunc};
      emit_out.first  = have_main ? main_res : trunc_res;
      emit_out.second = trunc_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         header_index_ff <= '0;
         id_skip_ff      <= '0;
         run_coded_ff    <= 1'b0;
         bpp_ff          <= BPP_NONE;
         width_ff        <= '0;
         height_ff       <= '0;
         pixels_ff       <= '0;
         packet_ff       <= '0;
         is_run_ff       <= 1'b0;
         cidx_ff         <= '0;
         colour_ff       <= '0;
      end else if (in_fire) begin
         phase_ff        <= phase_in;
         header_index_ff <= header_index_in;
         id_skip_ff      <= id_skip_in;
         run_coded_ff    <= run_coded_in;
         bpp_ff          <= bpp_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         pixels_ff       <= pixels_in;
         packet_ff       <= packet_in;
         is_run_ff       <= is_run_in;
         cidx_ff         <= cidx_in;
         colour_ff       <= colour_in;
      end
   end

endmodule

>>> src/tga_image_stream_decoder_top.sv
// TGA byte stream decoder top level: request handshake, decoder and response queue.
// Latency: responses reach the queue head no earlier than the cycle after acceptance.
// Throughput: one request per cycle unless stalled; a request yields zero, one or two
// responses; the response side drains one per cycle, unless rsp_stall is high, from
// a QUEUE_DEPTH-entry queue. Requests stall while fewer than two entries are free.
// Reset: decoder returns to idle (waits for a first byte), queue is emptied.
module tga_image_stream_decoder_top
   import tga_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_res,
   output logic        rsp_last_pixel,
   output logic [15:0] rsp_width,
   output logic [15:0] rsp_height,
   output logic        rsp_has_alpha
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic             req_fire;
   logic             rsp_fire;
   tga_emit_type     emit;
   logic [1:0]       push_n;
   tga_result_type   queue_ff [QUEUE_DEPTH];
   tga_result_type   head;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [CNT_W-1:0] count_ff, count_in;

   assign req_stall = (count_ff > CNT_W'(QUEUE_DEPTH - 2));
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && !rsp_stall;

   tga_dec_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (req_fire),
      .in_byte  (req_byte_value),
      .in_first (req_first_byte),
      .in_last  (req_last_byte),
      .emit_out (emit)
   );

   always_comb begin
      push_n      = req_fire ? emit.count : 2'd0;
      wr_ptr_next = wr_ptr_ff + PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in   = rd_ptr_ff + PTR_W'(rsp_fire);
      count_in    = count_ff + CNT_W'(push_n) - CNT_W'(rsp_fire);
   end

   // queue storage holds no reset
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= emit.first;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_next] <= emit.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head           = queue_ff[rd_ptr_ff];
   assign rsp_status     = head.status;
   assign rsp_red        = head.red;
   assign rsp_green      = head.green;
   assign rsp_blue       = head.blue;
   assign rsp_alpha      = head.alpha;
   assign rsp_repeat_res = head.repeat_res;
   assign rsp_last_pixel = head.last_pixel;
   assign rsp_width      = head.width;
   assign rsp_height     = head.height;
   assign rsp_has_alpha  = head.has_alpha;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("response queue overflow");

   a_span_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SPAN) |-> (rsp_repeat_res != 8'd0))
      else $error("pixel span with zero repeat");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_SPAN) |->
         (rsp_repeat_res == 8'd0 && !rsp_last_pixel && rsp_red == 8'd0 &&
          rsp_green == 8'd0 && rsp_blue == 8'd0 && rsp_alpha == 8'd0))
      else $error("status response carries pixel data");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the TGA stream decoder: directed table, then random files.
`timescale 1ns / 1ps

module testbench
   import tga_pkg::*;
();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 250;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           first;
      logic           last;
      logic           typed;
      tga_result_type want;
   } tga_req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = 8'h00;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_res;
   logic        rsp_last_pixel;
   logic [15:0] rsp_width;
   logic [15:0] rsp_height;
   logic        rsp_has_alpha;

   tga_req_item_type file_stream[$];
   tga_req_item_type offered;
   tga_result_type   decoded_results[$];
   logic [7:0]       file_bytes[$];
   int               queued_items = 0;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;

   // decoder state mirrored by the predictor
   tga_phase_type dec_phase = PH_IDLE;
   logic [4:0]    hdr_pos = '0;
   logic [7:0]    id_left = '0;
   logic          rle_mode = 1'b0;
   logic [2:0]    pix_bytes = BPP_NONE;
   logic [15:0]   img_w = '0;
   logic [15:0]   img_h = '0;
   logic [31:0]   pix_owed = '0;
   logic [7:0]    pkt_left = '0;
   logic          pkt_run = 1'b0;
   logic [1:0]    col_pos = '0;
   logic [31:0]   col_acc = '0;

   tga_image_stream_decoder_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_repeat_res (rsp_repeat_res),
      .rsp_last_pixel (rsp_last_pixel),
      .rsp_width      (rsp_width),
      .rsp_height     (rsp_height),
      .rsp_has_alpha  (rsp_has_alpha)
   );

   always #2 clock = ~clock;

   function automatic tga_result_type pack_decoded(tga_status_type st, logic [31:0] col,
                                                  logic [7:0] rep, logic last_px);
      tga_result_type r;
      r.status     = st;
      r.red        = col[23:16];
      r.green      = col[15:8];
      r.blue       = col[7:0];
      r.alpha      = (pix_bytes == BPP_RGBA) ? col[31:24] : 8'h00;
      r.repeat_res = rep;
      r.last_pixel = last_px;
      r.width      = img_w;
      r.height     = img_h;
      r.has_alpha  = (pix_bytes == BPP_RGBA);
      return r;
   endfunction

   // status-only result with header values typed in by hand
   function automatic tga_result_type status_result(tga_status_type st, logic [15:0] w,
                                                   logic [15:0] h, logic a);
      tga_result_type r;
      r            = '0;
      r.status     = st;
      r.width      = w;
      r.height     = h;
      r.has_alpha  = a;
      return r;
   endfunction

   task automatic start_pixels();
      if (pix_owed == 0)
         dec_phase = PH_DONE;
      else
         dec_phase = rle_mode ? PH_PKT : PH_PIX;
      col_pos  = '0;
      col_acc  = '0;
      pkt_left = '0;
      pkt_run  = 1'b0;
   endtask

   task automatic decode_tga_byte(logic [7:0] b, logic first, logic last);
      logic [31:0] rep;
      logic        last_px;
      if (first) begin
         hdr_pos   = '0;
         id_left   = '0;
         rle_mode  = 1'b0;
         pix_bytes = BPP_NONE;
         img_w     = '0;
         img_h     = '0;
         pix_owed  = '0;
         pkt_left  = '0;
         pkt_run   = 1'b0;
         col_pos   = '0;
         col_acc   = '0;
         dec_phase = PH_HEAD;
      end
      case (dec_phase)
         PH_HEAD: begin
            case (hdr_pos)
               HDR_ID_LEN: id_left = b;
               HDR_TYPE: begin
                  if (b == TYPE_RAW || b == TYPE_RLE) begin
                     rle_mode = (b == TYPE_RLE);
                  end else begin
                     decoded_results.push_back(pack_decoded(ST_BAD_TYPE, '0, '0, 1'b0));
                     dec_phase = PH_ERR;
                  end
               end
               HDR_WIDTH_LO:  img_w[7:0]  = b;
               HDR_WIDTH_HI:  img_w[15:8] = b;
               HDR_HEIGHT_LO: img_h[7:0]  = b;
               HDR_HEIGHT_HI: img_h[15:8] = b;
               HDR_DEPTH: begin
                  if (b == DEPTH_24 || b == DEPTH_32) begin
                     pix_bytes = (b == DEPTH_32) ? BPP_RGBA : BPP_RGB;
                  end else begin
                     decoded_results.push_back(pack_decoded(ST_BAD_DEPTH, '0, '0, 1'b0));
                     dec_phase = PH_ERR;
                  end
               end
               HDR_DESC: begin
                  decoded_results.push_back(pack_decoded(ST_HEADER_OK, '0, '0, 1'b0));
                  pix_owed = {16'd0, img_w} * {16'd0, img_h};
                  if (id_left != 0)
                     dec_phase = PH_IDSKIP;
                  else
                     start_pixels();
               end
               default: ;
            endcase
            if (hdr_pos < HDR_DESC)
               hdr_pos = hdr_pos + 5'd1;
         end
         PH_IDSKIP: begin
            id_left = id_left - 8'd1;
            if (id_left == 0)
               start_pixels();
         end
         PH_PKT: begin
            pkt_run   = b[PKT_RUN_BIT];
            pkt_left  = {1'b0, b[6:0] & PKT_COUNT_MASK} + 8'd1;
            col_pos   = '0;
            col_acc   = '0;
            dec_phase = PH_PIX;
         end
         PH_PIX: begin
            col_acc = col_acc | ({24'd0, b} << (8 * col_pos));
            if (col_pos + 1 >= pix_bytes) begin
               rep = 32'd1;
               if (rle_mode && pkt_run) begin
                  rep      = (pkt_left < pix_owed) ? {24'd0, pkt_left} : pix_owed;
                  pkt_left = '0;
               end else if (rle_mode && pkt_left != 0) begin
                  pkt_left = pkt_left - 8'd1;
               end
               pix_owed = pix_owed - rep;
               last_px  = (pix_owed == 0);
               decoded_results.push_back(pack_decoded(ST_SPAN, col_acc, rep[7:0], last_px));
               col_pos = '0;
               col_acc = '0;
               if (last_px)
                  dec_phase = PH_DONE;
               else if (rle_mode && pkt_left == 0)
                  dec_phase = PH_PKT;
            end else begin
               col_pos = col_pos + 2'd1;
            end
         end
         default: ;
      endcase
      if (last) begin
         if (dec_phase == PH_HEAD || dec_phase == PH_IDSKIP ||
             dec_phase == PH_PKT || dec_phase == PH_PIX)
            decoded_results.push_back(pack_decoded(ST_TRUNCATED, '0, '0, 1'b0));
         dec_phase = PH_IDLE;
      end
   endtask

   task automatic queue_byte(logic [7:0] b, logic first, logic last, logic typed,
                             tga_result_type want);
      tga_req_item_type it;
      it.data_byte = b;
      it.first     = first;
      it.last      = last;
      it.typed     = typed;
      it.want      = want;
      file_stream.push_back(it);
      queued_items++;
   endtask

   task automatic push_pixel(int unsigned bpp);
      for (int unsigned k = 0; k < bpp; k++)
         file_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // build one file (mostly well formed), then queue it with its first/last marks
   task automatic queue_random_file();
      int unsigned kind, bpp, w, h, owed, remain, cnt, id_len, end_pos, n_noise;
      bit          rle, run, with_last;
      kind = $urandom_range(0, 99);
      rle  = 1'($urandom_range(0, 1));
      bpp  = $urandom_range(0, 1) ? 4 : 3;

      // stray bytes between files
      if ($urandom_range(0, 9) == 0) begin
         n_noise = $urandom_range(1, 3);
         for (int unsigned k = 0; k < n_noise; k++)
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                       $urandom_range(0, 3) == 0, 1'b0, '0);
      end

      case ($urandom_range(0, 19))
         0:       begin w = 0; h = $urandom_range(0, 3); end
         1:       begin w = $urandom_range(0, 65535); h = $urandom_range(1, 65535); end
         2:       begin w = $urandom_range(1, 3); h = 0; end
         default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 4); end
      endcase
      owed = w * h;

      case ($urandom_range(0, 49))
         0:        id_len = $urandom_range(0, 255);
         1,2,3,4:  id_len = $urandom_range(1, 4);
         default:  id_len = 0;
      endcase

      file_bytes.delete();
      for (int unsigned k = 0; k < 18; k++)
         file_bytes.push_back(8'($urandom_range(0, 255)));
      file_bytes[HDR_ID_LEN]    = 8'(id_len);
      file_bytes[HDR_TYPE]      = (kind < 5) ? 8'($urandom_range(0, 255)) :
                                  (rle ? TYPE_RLE : TYPE_RAW);
      file_bytes[HDR_WIDTH_LO]  = w[7:0];
      file_bytes[HDR_WIDTH_HI]  = w[15:8];
      file_bytes[HDR_HEIGHT_LO] = h[7:0];
      file_bytes[HDR_HEIGHT_HI] = h[15:8];
      file_bytes[HDR_DEPTH]     = (kind >= 5 && kind < 10) ? 8'($urandom_range(0, 255)) :
                                  8'(bpp * 8);

      for (int unsigned k = 0; k < id_len; k++)
         file_bytes.push_back(8'($urandom_range(0, 255)));

      // cap the pixel data; huge images end up truncated
      remain = (owed < 40) ? owed : 40;
      while (remain > 0) begin
         if (rle) begin
            run = 1'($urandom_range(0, 1));
            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            file_bytes.push_back({run, 7'(cnt - 1)});
            if (run) begin
               push_pixel(bpp);
            end else begin
               for (int unsigned k = 0; k < cnt && k <= remain; k++)
                  push_pixel(bpp);
            end
            remain = (cnt < remain) ? remain - cnt : 0;
         end else begin
            push_pixel(bpp);
            remain--;
         end
      end

      // bytes past the image are dropped by the decoder
      if ($urandom_range(0, 4) == 0) begin
         n_noise = $urandom_range(1, 3);
         for (int unsigned k = 0; k < n_noise; k++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
      end

      with_last = 1'b1;
      end_pos   = file_bytes.size() - 1;
      case ($urandom_range(0, 19))
         0, 1:    end_pos = $urandom_range(0, file_bytes.size() - 1);
         2, 3, 4: with_last = 1'b0;
         default: ;
      endcase

      for (int unsigned k = 0; k <= end_pos; k++)
         queue_byte(file_bytes[k], k == 0, with_last && k == end_pos, 1'b0, '0);
   endtask

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("cycle %0d: %s", cycle_count, what);
   endtask

   task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // request side: predict on each accepted request, then load the next one
   always @(posedge clock) begin : drive_requests
      int base;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            base = decoded_results.size();
            decode_tga_byte(offered.data_byte, offered.first, offered.last);
            if (offered.typed) begin
               while (decoded_results.size() > base)
                  void'(decoded_results.pop_back());
               decoded_results.push_back(offered.want);
            end
         end
         if (!req_valid || !req_stall) begin
            if (file_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered = file_stream.pop_front();
               req_valid      <= 1'b1;
               req_byte_value <= offered.data_byte;
               req_first_byte <= offered.first;
               req_last_byte  <= offered.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side: check each accepted response against the oldest prediction
   always @(posedge clock) begin : check_responses
      tga_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_results.size() == 0) begin
               report_mismatch("response with nothing predicted");
            end else begin
               want = decoded_results.pop_front();
               compare_field("status", 16'(rsp_status), 16'(want.status));
               compare_field("red", 16'(rsp_red), 16'(want.red));
               compare_field("green", 16'(rsp_green), 16'(want.green));
               compare_field("blue", 16'(rsp_blue), 16'(want.blue));
               compare_field("alpha", 16'(rsp_alpha), 16'(want.alpha));
               compare_field("repeat_res", 16'(rsp_repeat_res), 16'(want.repeat_res));
               compare_field("last_pixel", 16'(rsp_last_pixel), 16'(want.last_pixel));
               compare_field("width", rsp_width, want.width);
               compare_field("height", rsp_height, want.height);
               compare_field("has_alpha", 16'(rsp_has_alpha), 16'(want.has_alpha));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tga_image_stream_decoder_top regression: fail");
         $finish;
      end
   end

   initial begin
      int target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 15; recv_idle_pct = 59; end
            1:       begin send_idle_pct = 59; recv_idle_pct = 15; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase

         if (ph == 0) begin
            // byte before any file
            queue_byte(8'h55, 1'b0, 1'b0, 1'b0, '0);
            // stream ends on its first header byte
            queue_byte(8'h00, 1'b1, 1'b1, 1'b1,
                       status_result(ST_TRUNCATED, 16'd0, 16'd0, 1'b0));
            // bad image type, then a byte ignored in the error state
            queue_byte(8'h00, 1'b1, 1'b0, 1'b0, '0);
            queue_byte(8'h00, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(8'h03, 1'b0, 1'b0, 1'b1,
                       status_result(ST_BAD_TYPE, 16'd0, 16'd0, 1'b0));
            queue_byte(8'hff, 1'b0, 1'b1, 1'b0, '0);
            // 2x1 RLE RGBA image, one maximal run clipped to two pixels
            queue_byte(8'h00, 1'b1, 1'b0, 1'b0, '0);
            queue_byte(8'h00, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(TYPE_RLE, 1'b0, 1'b0, 1'b0, '0);
            repeat (9) queue_byte(8'h00, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(8'h02, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(8'h00, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(8'h01, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(8'h00, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(DEPTH_32, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(8'h28, 1'b0, 1'b0, 1'b1,
                       status_result(ST_HEADER_OK, 16'd2, 16'd1, 1'b1));
            queue_byte(8'hff, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(8'h00, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(8'hff, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(8'h80, 1'b0, 1'b0, 1'b0, '0);
            queue_byte(8'hff, 1'b0, 1'b1, 1'b0, '0);
         end

         target = queued_items + PHASE_ITEMS;
         while (queued_items < target)
            queue_random_file();

         while (file_stream.size() != 0 || req_valid || decoded_results.size() != 0)
            @(posedge clock);
      end

      // catch any response the decoder should not have produced
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_results.size() != 0)
         report_mismatch("predicted responses never arrived");

      if (mismatch_count == 0) begin
         $display("tga_image_stream_decoder_top regression: pass");
      end else begin
         $display("tga_image_stream_decoder_top regression: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/tga_pkg.sv
src/tga_dec_core.sv
src/tga_image_stream_decoder_top.sv
tb/testbench.sv
